### sv/swm_pkg.sv
// Shared constants, types and ring helpers for the sliding window maximum block.
`default_nettype none
package swm_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int POS_BITS    = 16;
   localparam int SIZE_BITS   = 7;
   localparam int ADDR_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
   localparam int ENTRY_BITS  = SAMPLE_BITS + POS_BITS;

   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic [CNT_BITS-1:0]           cnt_type;
   typedef logic [POS_BITS-1:0]           pos_type;
   typedef logic [SIZE_BITS-1:0]          size_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [0:0] {
      CMP_AGE   = 1'b0,
      CMP_VALUE = 1'b1
   } cmp_mode_type;

   typedef struct packed {
      cmp_mode_type mode;
      pos_type      pos_now;
      pos_type      entry_pos;
      cnt_type      window;
      sample_type   entry_value;
      sample_type   sample;
   } cmp_req_type;

   function automatic addr_type ring_add(addr_type base, cnt_type offset);
      int s;
      s = int'(base) + int'(offset);
      if (s >= WINDOW_MAX) begin
         s = s - WINDOW_MAX;
      end
      return addr_type'(s);
   endfunction

   function automatic cnt_type clamp_window(size_type raw);
      cnt_type k;
      if (raw == '0) begin
         k = cnt_type'(1);
      end else if (int'(raw) > WINDOW_MAX) begin
         k = cnt_type'(WINDOW_MAX);
      end else begin
         k = cnt_type'(raw);
      end
      return k;
   endfunction

endpackage
`default_nettype wire

### sv/swm_if.sv
// Valid/ready channel interfaces for samples, results and the window size register.
`default_nettype none
interface swm_req_if;
   import swm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       end_of_stream;
   modport source (output valid, output sample, output end_of_stream, input ready);
   modport sink (input valid, input sample, input end_of_stream, output ready);
endinterface

interface swm_rsp_if;
   import swm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type window_max;
   logic       last_of_stream;
   modport source (output valid, output window_max, output last_of_stream, input ready);
   modport sink (input valid, input window_max, input last_of_stream, output ready);
endinterface

interface swm_csr_if;
   import swm_pkg::*;
   logic     valid;
   logic     ready;
   size_type window_size;
   modport source (output valid, output window_size, input ready);
   modport sink (input valid, input window_size, output ready);
endinterface
`default_nettype wire

### sv/swm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/swm_cmp.sv
// Shared decision unit: front entry age against the window, or back value against the sample.
`default_nettype none
module swm_cmp import swm_pkg::*; (
   input  wire cmp_req_type cmp_req,
   output logic             hit
);

   pos_type age;

   assign age = cmp_req.pos_now - cmp_req.entry_pos;

   always_comb begin
      case (cmp_req.mode)
         CMP_AGE:   hit = (age >= POS_BITS'(cmp_req.window));
         CMP_VALUE: hit = (cmp_req.entry_value < cmp_req.sample);
         default:   hit = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

### sv/sliding_window_maximum.sv
// Top level: monotonic deque sequencer for the sliding window maximum.
// Each sample steps through front reads and age checks, evicting stale candidates,
// then back reads and value checks, popping smaller ones, then push, output read and output.
// Throughput: one sample at a time; a new sample is taken only back in the idle state,
// and a result still waiting on the output holds the block.
// Reset (synchronous, active high) empties the deque and sets the window size to 1.
`default_nettype none
module sliding_window_maximum import swm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   swm_req_if.sink    req_chan,
   swm_rsp_if.source  rsp_chan,
   swm_csr_if.sink    csr_chan
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EV_RD   = 8'b0000_0010,
      S_EV_CHK  = 8'b0000_0100,
      S_POP_RD  = 8'b0000_1000,
      S_POP_CHK = 8'b0001_0000,
      S_PUSH    = 8'b0010_0000,
      S_OUT_RD  = 8'b0100_0000,
      S_OUT     = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   addr_type    head_ff, head_in;
   cnt_type     count_ff, count_in;
   cnt_type     fill_ff, fill_in;
   pos_type     pos_ff, pos_in;
   size_type    window_size_ff, window_size_in;
   sample_type  sample_ff, sample_in;
   logic        eos_ff, eos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sample_type  rsp_max_ff, rsp_max_in;
   logic        rsp_last_ff, rsp_last_in;

   cnt_type     window;
   addr_type    back_addr;
   addr_type    rd_addr;
   addr_type    wr_addr;
   logic        wr_en;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ENTRY_BITS-1:0] rd_data;
   sample_type  entry_value;
   pos_type     entry_pos;
   cmp_req_type cmp_req;
   logic        hit;
   logic        ring_full;
   logic        has_result;
   logic        rsp_load;
   logic        finish;

   assign window      = clamp_window(window_size_ff);
   assign back_addr   = ring_add(head_ff, count_ff - cnt_type'(1));
   assign ring_full   = (count_ff == cnt_type'(WINDOW_MAX));
   assign entry_value = sample_type'(rd_data[ENTRY_BITS-1:POS_BITS]);
   assign entry_pos   = rd_data[POS_BITS-1:0];

   assign rd_addr = (state_ff == S_POP_RD) ? back_addr : head_ff;
   assign wr_en   = (state_ff == S_PUSH);
   assign wr_addr = ring_full ? head_ff : ring_add(head_ff, count_ff);
   assign wr_data = {sample_ff, pos_ff};

   swm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_cand_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      cmp_req.mode        = (state_ff == S_POP_CHK) ? CMP_VALUE : CMP_AGE;
      cmp_req.pos_now     = pos_ff;
      cmp_req.entry_pos   = entry_pos;
      cmp_req.window      = window;
      cmp_req.entry_value = entry_value;
      cmp_req.sample      = sample_ff;
   end

   swm_cmp u_cmp (
      .cmp_req (cmp_req),
      .hit     (hit)
   );

   assign has_result = (fill_ff >= window);
   assign rsp_load   = (state_ff == S_OUT) && has_result && (!rsp_valid_ff || rsp_chan.ready);
   assign finish     = (state_ff == S_OUT) && (!has_result || rsp_load);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.window_max     = rsp_max_ff;
   assign rsp_chan.last_of_stream = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      sample_in      = sample_ff;
      eos_in         = eos_ff;
      window_size_in = window_size_ff;
      if (csr_chan.valid) begin
         window_size_in = csr_chan.window_size;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               sample_in = req_chan.sample;
               eos_in    = req_chan.end_of_stream;
               state_in  = S_EV_RD;
            end
         end
         S_EV_RD: begin
            state_in = (count_ff == '0) ? S_PUSH : S_EV_CHK;
         end
         S_EV_CHK: begin
            if (hit) begin
               head_in  = ring_add(head_ff, cnt_type'(1));
               count_in = count_ff - cnt_type'(1);
               state_in = S_EV_RD;
            end else begin
               state_in = S_POP_RD;
            end
         end
         S_POP_RD: begin
            state_in = (count_ff == '0) ? S_PUSH : S_POP_CHK;
         end
         S_POP_CHK: begin
            if (hit) begin
               count_in = count_ff - cnt_type'(1);
               state_in = S_POP_RD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (ring_full) begin
               head_in = ring_add(head_ff, cnt_type'(1));
            end else begin
               count_in = count_ff + cnt_type'(1);
            end
            pos_in = pos_ff + pos_type'(1);
            if (fill_ff < cnt_type'(WINDOW_MAX)) begin
               fill_in = fill_ff + cnt_type'(1);
            end
            state_in = S_OUT_RD;
         end
         S_OUT_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (finish) begin
               state_in = S_IDLE;
               if (eos_ff) begin
                  head_in  = '0;
                  count_in = '0;
                  fill_in  = '0;
                  pos_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_max_in   = entry_value;
         rsp_last_in  = eos_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         fill_ff        <= '0;
         pos_ff         <= '0;
         window_size_ff <= size_type'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         fill_ff        <= fill_in;
         pos_ff         <= pos_in;
         window_size_ff <= window_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      eos_ff      <= eos_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_last_ff <= rsp_last_in;
   end

   // The deque never holds more candidates than the ring has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(WINDOW_MAX))
      else $error("deque count exceeds ring depth");

   // A check state is only entered with a candidate to compare against.
   a_check_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EV_CHK || state_ff == S_POP_CHK) |-> (count_ff != '0))
      else $error("compare step on an empty deque");

   // An accepted transaction always starts with a front read.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_EV_RD))
      else $error("accepted transaction did not start the eviction step");

   // A result is only loaded while a full window has been seen.
   a_result_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (fill_ff != '0) && (state_ff == S_OUT))
      else $error("result loaded without a filled window");

endmodule
`default_nettype wire

### tb/sliding_window_maximum_tb.sv
// Self-checking testbench for the sliding window maximum block, with its own deque predictor.
`default_nettype none
module sliding_window_maximum_tb;
   import swm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 300;
   localparam int PHASE_ITEMS   = 200;

   typedef enum logic [0:0] {
      ROW_SAMPLE = 1'b0,
      ROW_WINDOW = 1'b1
   } row_kind_type;

   typedef enum logic [1:0] {
      MODE_WIDE    = 2'd0,
      MODE_NARROW  = 2'd1,
      MODE_FALLING = 2'd2,
      MODE_RISING  = 2'd3
   } sample_mode_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      bit           eos;
      bit           fixed;
      bit           gives;
      int           answer;
   } directed_row_type;

   typedef struct {
      bit         fixed;
      bit         gives;
      sample_type window_max;
      bit         last_of_stream;
   } typed_answer_type;

   typedef struct {
      sample_type window_max;
      bit         last_of_stream;
   } window_result_type;

   logic clock;
   logic reset;

   swm_req_if req_bus ();
   swm_rsp_if rsp_bus ();
   swm_csr_if csr_bus ();

   sliding_window_maximum dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   sample_type cand_val [WINDOW_MAX];
   pos_type    cand_pos [WINDOW_MAX];
   int         cand_head;
   int         cand_count;
   pos_type    next_pos;
   int         fill_count;
   size_type   window_reg;

   typed_answer_type  typed_answers [$];
   window_result_type pending_maxima [$];
   int                error_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                sent_count;

   directed_row_type directed_rows [27] = '{
      '{ROW_SAMPLE, -32768, 1'b0, 1'b1, 1'b1, -32768},
      '{ROW_SAMPLE,  32767, 1'b0, 1'b1, 1'b1,  32767},
      '{ROW_SAMPLE,      0, 1'b0, 1'b1, 1'b1,      0},
      '{ROW_SAMPLE,     -1, 1'b1, 1'b1, 1'b1,     -1},
      '{ROW_WINDOW,      0, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,  21845, 1'b1, 1'b1, 1'b1,  21845},
      '{ROW_SAMPLE, -21846, 1'b0, 1'b1, 1'b1, -21846},
      '{ROW_WINDOW,      3, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,      5, 1'b1, 1'b1, 1'b0,      0},
      '{ROW_SAMPLE,      7, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,      7, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,      3, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,      7, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_WINDOW,      2, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,     -5, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,     -6, 1'b1, 1'b0, 1'b0,      0},
      '{ROW_WINDOW,    127, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,    100, 1'b0, 1'b1, 1'b0,      0},
      '{ROW_SAMPLE,   -100, 1'b1, 1'b1, 1'b0,      0},
      '{ROW_WINDOW,      2, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,      1, 1'b0, 1'b1, 1'b0,      0},
      '{ROW_SAMPLE,      3, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,      2, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_WINDOW,      3, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,      0, 1'b1, 1'b0, 1'b0,      0},
      '{ROW_WINDOW,     64, 1'b0, 1'b0, 1'b0,      0},
      '{ROW_SAMPLE,     -7, 1'b1, 1'b1, 1'b0,      0}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int effective_window(size_type raw);
      if (raw == '0) begin
         return 1;
      end else if (int'(raw) > WINDOW_MAX) begin
         return WINDOW_MAX;
      end
      return int'(raw);
   endfunction

   function automatic void clear_stream_state();
      cand_head  = 0;
      cand_count = 0;
      next_pos   = '0;
      fill_count = 0;
   endfunction

   function automatic void predict_window_max(input sample_type value, input bit closing,
                                              output bit gives, output sample_type maximum);
      int      k;
      int      idx;
      pos_type age;
      k       = effective_window(window_reg);
      gives   = 1'b0;
      maximum = '0;
      while (cand_count > 0) begin
         age = next_pos - cand_pos[cand_head];
         if (int'(age) < k) begin
            break;
         end
         cand_head  = (cand_head + 1) % WINDOW_MAX;
         cand_count = cand_count - 1;
      end
      while (cand_count > 0 &&
             cand_val[(cand_head + cand_count - 1) % WINDOW_MAX] < value) begin
         cand_count = cand_count - 1;
      end
      if (cand_count >= WINDOW_MAX) begin
         cand_head  = (cand_head + 1) % WINDOW_MAX;
         cand_count = cand_count - 1;
      end
      idx           = (cand_head + cand_count) % WINDOW_MAX;
      cand_val[idx] = value;
      cand_pos[idx] = next_pos;
      cand_count    = cand_count + 1;
      next_pos      = next_pos + 1'b1;
      if (fill_count < WINDOW_MAX) begin
         fill_count = fill_count + 1;
      end
      if (fill_count >= k) begin
         gives   = 1'b1;
         maximum = cand_val[cand_head];
      end
      if (closing) begin
         clear_stream_state();
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count = error_count + 1;
   endtask

   always @(posedge clock) begin
      typed_answer_type  note;
      window_result_type got;
      window_result_type want;
      window_result_type fresh;
      bit                gives;
      sample_type        maximum;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            window_reg = csr_bus.window_size;
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_window_max(req_bus.sample, req_bus.end_of_stream, gives, maximum);
            note = typed_answers[0];
            typed_answers.delete(0);
            if (note.fixed) begin
               gives   = note.gives;
               maximum = note.window_max;
            end
            if (gives) begin
               fresh.window_max     = maximum;
               fresh.last_of_stream = req_bus.end_of_stream;
               pending_maxima       = {pending_maxima, fresh};
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.window_max, rsp_bus.last_of_stream};
            if (pending_maxima.size() == 0) begin
               report_mismatch($sformatf("result %0d with nothing expected", got.window_max));
            end else begin
               want = pending_maxima[0];
               pending_maxima.delete(0);
               if (got.window_max !== want.window_max) begin
                  report_mismatch($sformatf("window_max %0d, expected %0d",
                                            got.window_max, want.window_max));
               end
               if (got.last_of_stream !== want.last_of_stream) begin
                  report_mismatch($sformatf("last_of_stream %0b, expected %0b",
                                            got.last_of_stream, want.last_of_stream));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_sample(input sample_type value, input bit closing, input bit fixed,
                              input bit gives, input sample_type answer);
      typed_answer_type note;
      note.fixed          = fixed;
      note.gives          = gives;
      note.window_max     = answer;
      note.last_of_stream = closing;
      typed_answers       = {typed_answers, note};
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sample        <= value;
      req_bus.end_of_stream <= closing;
      do @(posedge clock); while (!req_bus.ready);
      sent_count = sent_count + 1;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_maxima.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input size_type size);
      settle();
      csr_bus.valid       <= 1'b1;
      csr_bus.window_size <= size;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_stream(input size_type size);
      int              k;
      int              length;
      int              change_at;
      sample_mode_type mode;
      sample_type      level;
      k = effective_window(size);
      if ($urandom_range(9) == 0) begin
         length = $urandom_range(1, (k > 1) ? k - 1 : 1);
      end else begin
         length = $urandom_range(k, 2 * k + 8);
      end
      change_at = ($urandom_range(3) == 0 && length > 1) ? $urandom_range(1, length - 1) : -1;
      mode      = sample_mode_type'($urandom_range(3));
      level     = sample_type'($urandom_range(65535));
      for (int i = 0; i < length; i++) begin
         if (i == change_at) begin
            write_window(size_type'($urandom_range(1, WINDOW_MAX)));
         end
         case (mode)
            MODE_WIDE: begin
               level = sample_type'($urandom_range(65535));
            end
            MODE_NARROW: begin
               level = sample_type'(int'($urandom_range(7)) - 4);
            end
            MODE_FALLING: begin
               level = ($urandom_range(15) == 0) ? sample_type'($urandom_range(65535))
                                                 : level - sample_type'($urandom_range(3));
            end
            default: begin
               level = ($urandom_range(15) == 0) ? sample_type'($urandom_range(65535))
                                                 : level + sample_type'($urandom_range(3));
            end
         endcase
         send_sample(level, i == length - 1, 1'b0, 1'b0, '0);
      end
   endtask

   initial begin
      int       idle_plan [4][2];
      size_type size;
      idle_plan = '{'{0, 0}, '{71, 0}, '{0, 71}, '{12, 12}};
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.sample        = '0;
      req_bus.end_of_stream = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.window_size   = '0;
      error_count           = 0;
      sent_count            = 0;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      window_reg            = size_type'(1);
      clear_stream_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WINDOW) begin
            write_window(size_type'(directed_rows[r].value));
         end else begin
            send_sample(sample_type'(directed_rows[r].value), directed_rows[r].eos,
                        directed_rows[r].fixed, directed_rows[r].gives,
                        sample_type'(directed_rows[r].answer));
         end
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p][0];
         rsp_stall_pct = idle_plan[p][1];
         sent_count    = 0;
         while (sent_count < PHASE_ITEMS) begin
            case ($urandom_range(5))
               0: size = size_type'(1);
               1: size = size_type'(WINDOW_MAX);
               2: size = '0;
               3: size = '1;
               4: size = size_type'($urandom_range(1, WINDOW_MAX));
               default: size = size_type'($urandom_range(127));
            endcase
            write_window(size);
            run_stream(size);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("[sliding_window_maximum] OK");
      end else begin
         $display("[sliding_window_maximum] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[sliding_window_maximum] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
